/* src/arrt_pkg.sv */
// ----------------------------------------------------------------------------
// arrt_pkg - shared types and codes of the address range region translator
// operation and status codes, the search token handed along the region
// cells, the result beat and the controller states
// ----------------------------------------------------------------------------
package arrt_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_COMMIT = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_XLATE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_INVALID    = 3'd1,
      ST_NO_DEV     = 3'd2,
      ST_FAULT      = 3'd3,
      ST_OUT_FULL   = 3'd4,
      ST_TABLE_FULL = 3'd5
   } status_type;

   localparam logic KIND_SEG    = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // register index as seen on address bit 2
   localparam logic REG_VM_ID    = 1'b0;
   localparam logic REG_XLATE_ON = 1'b1;

   typedef enum logic {
      TOK_SEARCH = 1'b0,
      TOK_ADD    = 1'b1
   } tok_op_type;

   // token walking the cell row: a search carries the best region so far,
   // an add carries the new region and whether a free cell took it
   typedef struct packed {
      logic        valid;
      tok_op_type  op;
      logic [63:0] s;
      logic [63:0] lastr;
      logic [63:0] tgt;
      logic        found;
      logic        placed;
      logic [63:0] best_first;
      logic [63:0] best_last;
      logic [63:0] best_target;
   } token_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] seg_addr;
      logic [63:0] seg_len;
      status_type  status;
      logic [15:0] count;
      logic        use_translated;
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_CHECK,
      S_SEARCH,
      S_ADD_WAIT,
      S_PIECE,
      S_REBASE,
      S_DONE,
      S_END
   } state_type;

endpackage

/* src/arrt_cell.sv */
// ----------------------------------------------------------------------------
// arrt_cell - one region entry of the translator
// holds a region and updates the token passing through it each cycle
// ----------------------------------------------------------------------------
module arrt_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               drop,
   input  arrt_pkg::token_type tok_in,
   output arrt_pkg::token_type tok_out
);

   logic [63:0]         first_ff;
   logic [63:0]         last_ff;
   logic [63:0]         target_ff;
   logic                used_ff;
   arrt_pkg::token_type tok_ff;
   arrt_pkg::token_type tok_in_next;
   logic                hit;
   logic                take;
   logic                claim;

   assign hit   = used_ff && (first_ff <= tok_in.lastr) && (last_ff >= tok_in.s);
   assign take  = tok_in.valid && (tok_in.op == arrt_pkg::TOK_SEARCH) && hit &&
                  (!tok_in.found || (first_ff < tok_in.best_first));
   assign claim = tok_in.valid && (tok_in.op == arrt_pkg::TOK_ADD) &&
                  !used_ff && !tok_in.placed;

   always_comb begin
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found       = 1'b1;
         tok_in_next.best_first  = first_ff;
         tok_in_next.best_last   = last_ff;
         tok_in_next.best_target = target_ff;
      end
      if (claim) begin
         tok_in_next.placed = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
         if (drop) begin
            used_ff <= 1'b0;
         end else if (claim) begin
            used_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (claim) begin
         first_ff  <= tok_in.s;
         last_ff   <= tok_in.lastr;
         target_ff <= tok_in.tgt;
      end
   end

   assign tok_out = tok_ff;

`ifndef SYNTHESIS
   a_claim_marks_placed: assert property (@(posedge clock) disable iff (reset)
      claim |=> tok_out.placed) else $error("claimed add token not marked placed");
   a_claim_sets_used: assert property (@(posedge clock) disable iff (reset)
      (claim && !drop) |=> used_ff) else $error("claimed cell not in use");
   a_drop_frees: assert property (@(posedge clock) disable iff (reset)
      drop |=> !used_ff) else $error("cell still in use after drop");
   a_take_best: assert property (@(posedge clock) disable iff (reset)
      take |=> (tok_out.found && (tok_out.best_first == $past(first_ff))))
      else $error("search token missed a better region");
`endif

endmodule

/* src/address_range_region_translator.sv */
// ----------------------------------------------------------------------------
// address_range_region_translator - guest region table with range translation
// keeps up to NUM_REGIONS regions in a row of cells and splits, checks and
// rebases guest ranges against them
// ----------------------------------------------------------------------------
// One input beat is handled at a time. Every region lookup sends a token down
// the row of NUM_REGIONS cells, one cell per cycle. A translate beat makes one
// lookup per region that its range crosses, but a range inside the most
// recently used region skips the walk and a rejected range makes none; an add
// walks the row once to claim a free cell; commit and clear make no walk.
// Results leave through a one-beat staging slot and an output register, so
// the last flag of a beat is known before it is shown; a stalled rsp side
// holds the controller only when both are full. Regions are held in the
// cells and never read back directly: the controller keeps a copy of the
// last region found as a cache.
// Configuration: own vm id at byte address 0, translation on at address 4.
// ----------------------------------------------------------------------------
module address_range_region_translator #(
   parameter int NUM_REGIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_vm_id,
   input  logic [63:0] req_range_start,
   input  logic [63:0] req_range_len,
   input  logic [63:0] req_target_base,
   input  logic [15:0] req_out_limit,
   input  logic        req_last_in_request,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [63:0] rsp_seg_addr,
   output logic [63:0] rsp_seg_len,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_count,
   output logic        rsp_use_translated,
   output logic        rsp_last,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // controller state
   arrt_pkg::state_type  state_ff, state_in;

   // latched request beat
   arrt_pkg::op_type     op_ff;
   logic [15:0]          vm_ff;
   logic [63:0]          s_ff;          // current start, moves on per piece
   logic [63:0]          len_ff;
   logic [63:0]          len_m1_ff;
   logic [63:0]          tgt_ff;
   logic [15:0]          limit_ff;
   logic                 fin_ff;
   logic [63:0]          lastr_ff;

   // region in use for the current piece
   logic [63:0]          rf_ff, rl_ff, rt_ff;
   // copy of the most recently found region
   logic [63:0]          cf_ff, cl_ff, ct_ff;
   logic                 cache_valid_ff;

   // piece arithmetic
   logic                 piece_last_ff;
   logic [63:0]          piece_len_ff;
   logic [63:0]          off_ff;

   // table and request bookkeeping
   logic                 table_valid_ff;
   logic [15:0]          out_count_ff;
   logic [15:0]          range_count_ff;
   arrt_pkg::status_type req_err_ff;

   // configuration
   logic [15:0]          own_vm_ff;
   logic                 xlate_on_ff;

   // staging slot and output register
   arrt_pkg::result_type stage_ff;
   logic                 stage_valid_ff;
   arrt_pkg::result_type rsp_ff;
   logic                 rsp_last_ff;
   logic                 rsp_valid_ff;

   // cell row
   arrt_pkg::token_type  tok [NUM_REGIONS+1];
   arrt_pkg::token_type  chain_out;

   // control from the output decode
   logic                 stage_push;
   arrt_pkg::result_type stage_data;
   logic                 end_pop;
   logic                 pop;
   logic                 drop_all;
   logic                 set_tv, clr_tv;
   logic                 set_err;
   arrt_pkg::status_type err_val;
   logic                 load_cache_region;
   logic                 load_chain_region;
   logic                 count_inc;
   logic                 range_inc;
   logic                 req_end;
   logic                 advance;

   // shared datapath terms
   logic                 out_free;
   logic                 push_ok;
   logic                 vm_ok;
   logic [64:0]          sum65;
   logic [64:0]          reb65;
   logic                 cache_hit;
   logic                 search_ok;
   logic [63:0]          piece_end;
   logic [15:0]          range_count_next;
   logic                 req_ok;
   logic                 csr_write;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign push_ok   = !stage_valid_ff || out_free;
   assign vm_ok     = (vm_ff == own_vm_ff);
   assign sum65     = {1'b0, s_ff} + {1'b0, len_m1_ff};
   assign reb65     = {1'b0, off_ff} + {1'b0, rt_ff};
   assign cache_hit = cache_valid_ff && (s_ff >= cf_ff) && (lastr_ff <= cl_ff);
   assign chain_out = tok[NUM_REGIONS];
   assign search_ok = chain_out.found && (chain_out.best_first <= s_ff);
   assign piece_end = (lastr_ff <= rl_ff) ? lastr_ff : rl_ff;
   assign req_ok    = (req_err_ff == arrt_pkg::ST_OK);
   assign range_count_next = (req_ok && (range_count_ff != 16'hFFFF)) ?
                             range_count_ff + 16'd1 : range_count_ff;

   // ---------------------------------------------------------------------
   // region cells: the token enters cell 0 and comes back out of the last
   // ---------------------------------------------------------------------
   always_comb begin
      tok[0]             = '0;
      tok[0].op          = arrt_pkg::TOK_SEARCH;
      tok[0].lastr       = lastr_ff;
      tok[0].s           = s_ff;
      if (state_ff == arrt_pkg::S_DECODE) begin
         // add token: new region rides in the search fields
         tok[0].valid = (op_ff == arrt_pkg::OP_ADD) && vm_ok && (s_ff != 64'd0) &&
                        !sum65[64];
         tok[0].op    = arrt_pkg::TOK_ADD;
         tok[0].lastr = sum65[63:0];
         tok[0].tgt   = tgt_ff;
      end else if (state_ff == arrt_pkg::S_CHECK) begin
         tok[0].valid = !cache_hit;
      end else if (state_ff == arrt_pkg::S_REBASE) begin
         // next piece starts just past the region
         tok[0].valid = advance && !piece_last_ff;
         tok[0].s     = rl_ff + 64'd1;
      end
   end

   for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_cell
      arrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .drop    (drop_all),
         .tok_in  (tok[g]),
         .tok_out (tok[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         arrt_pkg::S_IDLE: begin
            if (req_valid) state_in = arrt_pkg::S_DECODE;
         end
         arrt_pkg::S_DECODE: begin
            if (op_ff != arrt_pkg::OP_XLATE) begin
               if (tok[0].valid) state_in = arrt_pkg::S_ADD_WAIT;
               else              state_in = arrt_pkg::S_END;
            end else if (!req_ok || !vm_ok || !table_valid_ff ||
                         (xlate_on_ff && (limit_ff == 16'd0)) ||
                         (len_ff == 64'd0) || sum65[64]) begin
               state_in = arrt_pkg::S_DONE;
            end else begin
               state_in = arrt_pkg::S_CHECK;
            end
         end
         arrt_pkg::S_CHECK: begin
            state_in = cache_hit ? arrt_pkg::S_PIECE : arrt_pkg::S_SEARCH;
         end
         arrt_pkg::S_SEARCH: begin
            if (chain_out.valid) begin
               state_in = search_ok ? arrt_pkg::S_PIECE : arrt_pkg::S_DONE;
            end
         end
         arrt_pkg::S_ADD_WAIT: begin
            if (chain_out.valid) state_in = arrt_pkg::S_END;
         end
         arrt_pkg::S_PIECE: begin
            state_in = arrt_pkg::S_REBASE;
         end
         arrt_pkg::S_REBASE: begin
            if (set_err) begin
               state_in = arrt_pkg::S_DONE;
            end else if (advance) begin
               state_in = piece_last_ff ? arrt_pkg::S_DONE : arrt_pkg::S_SEARCH;
            end
         end
         arrt_pkg::S_DONE: begin
            if (!fin_ff || push_ok) state_in = arrt_pkg::S_END;
         end
         arrt_pkg::S_END: begin
            if (!stage_valid_ff || out_free) state_in = arrt_pkg::S_IDLE;
         end
         default: state_in = arrt_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // controller outputs
   // ---------------------------------------------------------------------
   always_comb begin
      stage_push        = 1'b0;
      stage_data        = '0;
      stage_data.status = arrt_pkg::ST_OK;
      end_pop           = 1'b0;
      drop_all          = 1'b0;
      set_tv            = 1'b0;
      clr_tv            = 1'b0;
      set_err           = 1'b0;
      err_val           = arrt_pkg::ST_OK;
      load_cache_region = 1'b0;
      load_chain_region = 1'b0;
      count_inc         = 1'b0;
      range_inc         = 1'b0;
      req_end           = 1'b0;
      advance           = 1'b0;
      unique case (state_ff)
         arrt_pkg::S_DECODE: begin
            if (op_ff != arrt_pkg::OP_XLATE) begin
               stage_data.kind = arrt_pkg::KIND_STATUS;
               stage_push      = !tok[0].valid;
               if (!vm_ok) begin
                  stage_data.status = arrt_pkg::ST_NO_DEV;
               end else begin
                  unique case (op_ff)
                     arrt_pkg::OP_ADD: begin
                        if (!tok[0].valid) begin
                           stage_data.status = arrt_pkg::ST_INVALID;
                           drop_all          = 1'b1;
                        end
                     end
                     arrt_pkg::OP_COMMIT: set_tv = 1'b1;
                     default: begin
                        drop_all = 1'b1;
                        clr_tv   = 1'b1;
                     end
                  endcase
               end
            end else if (req_ok) begin
               priority if (!vm_ok) begin
                  set_err = 1'b1;
                  err_val = arrt_pkg::ST_NO_DEV;
               end else if (!table_valid_ff ||
                            (xlate_on_ff && (limit_ff == 16'd0)) ||
                            (len_ff == 64'd0) || sum65[64]) begin
                  set_err = 1'b1;
                  err_val = arrt_pkg::ST_INVALID;
               end
            end
         end
         arrt_pkg::S_CHECK: begin
            load_cache_region = cache_hit;
         end
         arrt_pkg::S_SEARCH: begin
            if (chain_out.valid) begin
               if (search_ok) begin
                  load_chain_region = 1'b1;
               end else begin
                  set_err = 1'b1;
                  err_val = arrt_pkg::ST_FAULT;
               end
            end
         end
         arrt_pkg::S_ADD_WAIT: begin
            if (chain_out.valid) begin
               stage_push      = 1'b1;
               stage_data.kind = arrt_pkg::KIND_STATUS;
               if (!chain_out.placed) begin
                  stage_data.status = arrt_pkg::ST_TABLE_FULL;
                  drop_all          = 1'b1;
               end
            end
         end
         arrt_pkg::S_REBASE: begin
            if (!xlate_on_ff) begin
               advance = 1'b1;
            end else if (reb65[64]) begin
               set_err = 1'b1;
               err_val = arrt_pkg::ST_INVALID;
            end else if (out_count_ff >= limit_ff) begin
               set_err = 1'b1;
               err_val = arrt_pkg::ST_OUT_FULL;
            end else if (push_ok) begin
               stage_push                = 1'b1;
               stage_data.kind           = arrt_pkg::KIND_SEG;
               stage_data.seg_addr       = reb65[63:0];
               stage_data.seg_len        = piece_len_ff;
               stage_data.use_translated = 1'b1;
               count_inc                 = 1'b1;
               advance                   = 1'b1;
            end
         end
         arrt_pkg::S_DONE: begin
            range_inc = !fin_ff || push_ok;
            if (fin_ff && push_ok) begin
               stage_push                = 1'b1;
               stage_data.kind           = arrt_pkg::KIND_STATUS;
               stage_data.status         = req_err_ff;
               stage_data.count          = !req_ok ? 16'd0 :
                                           (xlate_on_ff ? out_count_ff : range_count_next);
               stage_data.use_translated = req_ok && xlate_on_ff;
               req_end                   = 1'b1;
            end
         end
         arrt_pkg::S_END: begin
            end_pop = stage_valid_ff && out_free;
         end
         default: begin
         end
      endcase
   end

   // the held beat leaves once its follower or the end of the beat is known
   assign pop = stage_valid_ff && out_free && (stage_push || end_pop);

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= arrt_pkg::S_IDLE;
         table_valid_ff <= 1'b0;
         cache_valid_ff <= 1'b0;
         out_count_ff   <= 16'd0;
         range_count_ff <= 16'd0;
         req_err_ff     <= arrt_pkg::ST_OK;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         own_vm_ff      <= 16'd0;
         xlate_on_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (set_tv)      table_valid_ff <= 1'b1;
         else if (clr_tv) table_valid_ff <= 1'b0;

         if (drop_all || req_end)    cache_valid_ff <= 1'b0;
         else if (load_chain_region) cache_valid_ff <= 1'b1;

         if (req_end) begin
            out_count_ff   <= 16'd0;
            range_count_ff <= 16'd0;
            req_err_ff     <= arrt_pkg::ST_OK;
         end else begin
            if (count_inc) out_count_ff   <= out_count_ff + 16'd1;
            if (range_inc) range_count_ff <= range_count_next;
            if (set_err)   req_err_ff     <= err_val;
         end

         if (stage_push) stage_valid_ff <= 1'b1;
         else if (pop)   stage_valid_ff <= 1'b0;

         if (pop)            rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         if (csr_write) begin
            if (csr_paddr[2] == arrt_pkg::REG_VM_ID) own_vm_ff   <= csr_pwdata[15:0];
            else                                     xlate_on_ff <= csr_pwdata[0];
         end
      end
   end

   // ---------------------------------------------------------------------
   // datapath registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if ((state_ff == arrt_pkg::S_IDLE) && req_valid) begin
         op_ff     <= arrt_pkg::op_type'(req_operation);
         vm_ff     <= req_vm_id;
         s_ff      <= req_range_start;
         len_ff    <= req_range_len;
         len_m1_ff <= req_range_len - 64'd1;
         tgt_ff    <= req_target_base;
         limit_ff  <= req_out_limit;
         fin_ff    <= req_last_in_request;
      end
      if (state_ff == arrt_pkg::S_DECODE) begin
         lastr_ff <= sum65[63:0];
      end
      if (load_cache_region) begin
         rf_ff <= cf_ff;
         rl_ff <= cl_ff;
         rt_ff <= ct_ff;
      end else if (load_chain_region) begin
         rf_ff <= chain_out.best_first;
         rl_ff <= chain_out.best_last;
         rt_ff <= chain_out.best_target;
      end
      if (load_chain_region) begin
         cf_ff <= chain_out.best_first;
         cl_ff <= chain_out.best_last;
         ct_ff <= chain_out.best_target;
      end
      if (state_ff == arrt_pkg::S_PIECE) begin
         piece_last_ff <= (lastr_ff <= rl_ff);
         piece_len_ff  <= piece_end - s_ff + 64'd1;
         off_ff        <= s_ff - rf_ff;
      end
      if (advance && !piece_last_ff) begin
         s_ff <= rl_ff + 64'd1;
      end
      if (stage_push) begin
         stage_ff <= stage_data;
      end
      if (pop) begin
         rsp_ff      <= stage_ff;
         rsp_last_ff <= !stage_push;
      end
   end

   // ---------------------------------------------------------------------
   // ports
   // ---------------------------------------------------------------------
   assign req_ready          = (state_ff == arrt_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_seg_addr       = rsp_ff.seg_addr;
   assign rsp_seg_len        = rsp_ff.seg_len;
   assign rsp_status         = rsp_ff.status;
   assign rsp_count          = rsp_ff.count;
   assign rsp_use_translated = rsp_ff.use_translated;
   assign rsp_last           = rsp_last_ff;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == arrt_pkg::REG_XLATE_ON) ?
                       {31'd0, xlate_on_ff} : {16'd0, own_vm_ff};

`ifndef SYNTHESIS
   a_seg_needs_xlate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == arrt_pkg::KIND_SEG)) |-> rsp_use_translated)
      else $error("segment beat without translation flag");
   a_err_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != arrt_pkg::ST_OK)) |-> (rsp_count == 16'd0))
      else $error("failed status carries a count");
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid) else $error("popped beat not shown");
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arrt_pkg::S_IDLE) |-> !stage_valid_ff)
      else $error("staged beat left behind at idle");
`endif

endmodule

/* sim/tb_address_range_region_translator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_range_region_translator - self-checking bench for the translator
// drives operation and translate beats with random idling on both channels,
// predicts every result beat from its own copy of the region table and
// compares the result stream in order, across several register settings
// ----------------------------------------------------------------------------
module tb_address_range_region_translator;

   localparam int NREG      = 16;
   localparam int DOG_LIMIT = 4000;  // idle cycles before the run is called hung
   localparam int SETTLE    = 500;   // a 16-region walk is well under this

   typedef struct {
      arrt_pkg::op_type op;
      logic [15:0]      vm;
      logic [63:0]      start;
      logic [63:0]      len;
      logic [63:0]      tgt;
      logic [15:0]      lim;
      logic             fin;
   } req_beat_type;

   typedef struct {
      logic        kind;
      logic [63:0] addr;
      logic [63:0] len;
      logic [2:0]  status;
      logic [15:0] count;
      logic        use_x;
      logic        last;
   } rsp_beat_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_operation = 0;
   logic [15:0] req_vm_id = 0;
   logic [63:0] req_range_start = 0;
   logic [63:0] req_range_len = 0;
   logic [63:0] req_target_base = 0;
   logic [15:0] req_out_limit = 0;
   logic        req_last_in_request = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic        rsp_kind;
   logic [63:0] rsp_seg_addr;
   logic [63:0] rsp_seg_len;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_count;
   logic        rsp_use_translated;
   logic        rsp_last;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   address_range_region_translator #(.NUM_REGIONS(NREG)) u_top (.*);

   // 4 ns clock
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   req_beat_type pending_q[$];
   rsp_beat_type expected_q[$];
   int           errors = 0;
   bit           calm = 0;      // no idling in the closing stretch
   bit           beat_taken = 0;

   // ---------------------------------------------------------------------
   // predictor state: region table, cache, request bookkeeping, registers
   // ---------------------------------------------------------------------
   logic [63:0] rg_first[NREG];
   logic [63:0] rg_final[NREG];
   logic [63:0] rg_target[NREG];
   bit          rg_used[NREG];
   bit          tbl_valid = 0;
   int unsigned hot_idx = 0;
   bit          hot_ok = 0;
   int unsigned seg_cnt = 0;
   int unsigned chk_cnt = 0;
   logic [2:0]  req_err = arrt_pkg::ST_OK;
   logic [15:0] vm_reg = 0;
   bit          xlate_reg = 0;

   function automatic void push_result(logic kind, logic [63:0] addr, logic [63:0] len,
                                       logic [2:0] st, logic [15:0] cnt, logic use_x);
      rsp_beat_type r;
      r.kind = kind; r.addr = addr; r.len = len; r.status = st;
      r.count = cnt; r.use_x = use_x; r.last = 0;
      expected_q.push_back(r);
   endfunction

   function automatic void drop_table();
      for (int i = 0; i < NREG; i++) rg_used[i] = 0;
      hot_ok  = 0;
      hot_idx = 0;
   endfunction

   // rebase one piece and queue it; 0 when the request picked up an error
   function automatic bit emit_piece(int unsigned idx, logic [63:0] s, logic [63:0] len,
                                     logic [15:0] lim);
      logic [63:0] off, addr;
      if (!xlate_reg) return 1;
      off  = s - rg_first[idx];
      addr = off + rg_target[idx];
      if (addr < off) begin
         req_err = arrt_pkg::ST_INVALID;
         return 0;
      end
      if (seg_cnt >= lim) begin
         req_err = arrt_pkg::ST_OUT_FULL;
         return 0;
      end
      push_result(arrt_pkg::KIND_SEG, addr, len, arrt_pkg::ST_OK, 0, 1);
      seg_cnt++;
      return 1;
   endfunction

   function automatic void split_range(logic [63:0] s, logic [63:0] len, logic [15:0] lim);
      logic [63:0] lastr;
      bit          found;
      int unsigned f;
      if (len == 0) begin
         req_err = arrt_pkg::ST_INVALID;
         return;
      end
      lastr = s + (len - 1);
      if (lastr < s) begin
         req_err = arrt_pkg::ST_INVALID;
         return;
      end
      // most recent region first
      if (hot_ok && rg_used[hot_idx] && s >= rg_first[hot_idx] && lastr <= rg_final[hot_idx])
      begin
         void'(emit_piece(hot_idx, s, len, lim));
         return;
      end
      for (int it = 0; it <= NREG; it++) begin
         found = 0;
         f = 0;
         for (int i = 0; i < NREG; i++)
            if (rg_used[i] && rg_first[i] <= lastr && rg_final[i] >= s &&
                (!found || rg_first[i] < rg_first[f])) begin
               f = i;
               found = 1;
            end
         // miss, or a hole in front of the lowest overlapping region
         if (!found || rg_first[f] > s) begin
            req_err = arrt_pkg::ST_FAULT;
            return;
         end
         hot_idx = f;
         hot_ok  = 1;
         if (lastr > rg_final[f]) begin
            if (!emit_piece(f, s, rg_final[f] - s + 1, lim)) return;
            s = rg_final[f] + 1;
            continue;
         end
         void'(emit_piece(f, s, lastr - s + 1, lim));
         return;
      end
      req_err = arrt_pkg::ST_FAULT;
   endfunction

   function automatic void predict_beat(req_beat_type b);
      int          n0;
      logic [2:0]  st;
      logic [63:0] fl;
      int          slot;
      bit          ok;
      n0 = expected_q.size();
      if (b.op != arrt_pkg::OP_XLATE) begin
         st = arrt_pkg::ST_OK;
         if (b.vm != vm_reg) st = arrt_pkg::ST_NO_DEV;
         else if (b.op == arrt_pkg::OP_ADD) begin
            fl = b.start + (b.len - 1);
            slot = NREG;
            for (int i = NREG - 1; i >= 0; i--) if (!rg_used[i]) slot = i;
            if (b.start == 0 || fl < b.start) begin
               st = arrt_pkg::ST_INVALID;
               drop_table();
            end else if (slot >= NREG) begin
               st = arrt_pkg::ST_TABLE_FULL;
               drop_table();
            end else begin
               rg_first[slot]  = b.start;
               rg_final[slot]  = fl;
               rg_target[slot] = b.tgt;
               rg_used[slot]   = 1;
            end
         end else if (b.op == arrt_pkg::OP_COMMIT) tbl_valid = 1;
         else begin
            drop_table();
            tbl_valid = 0;
         end
         push_result(arrt_pkg::KIND_STATUS, 0, 0, st, 0, 0);
      end else begin
         // only the first error of a request counts, later ranges are skipped
         if (req_err == arrt_pkg::ST_OK) begin
            if (b.vm != vm_reg) req_err = arrt_pkg::ST_NO_DEV;
            else if (!tbl_valid) req_err = arrt_pkg::ST_INVALID;
            else if (xlate_reg && b.lim == 0) req_err = arrt_pkg::ST_INVALID;
            else split_range(b.start, b.len, b.lim);
            if (req_err == arrt_pkg::ST_OK && chk_cnt < 16'hFFFF) chk_cnt++;
         end
         if (b.fin) begin
            ok = (req_err == arrt_pkg::ST_OK);
            push_result(arrt_pkg::KIND_STATUS, 0, 0, req_err,
                        ok ? (xlate_reg ? seg_cnt[15:0] : chk_cnt[15:0]) : 16'd0,
                        ok && xlate_reg);
            seg_cnt = 0;
            chk_cnt = 0;
            req_err = arrt_pkg::ST_OK;
            hot_ok  = 0;
         end
      end
      if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: checks result beats, then feeds accepted request beats on
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_beat_type e;
      req_beat_type b;
      beat_taken = 0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat kind %0d status %0d", $time,
                        rsp_kind, rsp_status);
            end else begin
               e = expected_q.pop_front();
               if (rsp_kind !== e.kind) begin
                  errors++;
                  $display("%0t: kind exp %0d got %0d", $time, e.kind, rsp_kind);
               end
               if (rsp_seg_addr !== e.addr) begin
                  errors++;
                  $display("%0t: seg_addr exp %h got %h", $time, e.addr, rsp_seg_addr);
               end
               if (rsp_seg_len !== e.len) begin
                  errors++;
                  $display("%0t: seg_len exp %h got %h", $time, e.len, rsp_seg_len);
               end
               if (rsp_status !== e.status) begin
                  errors++;
                  $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               end
               if (rsp_count !== e.count) begin
                  errors++;
                  $display("%0t: count exp %0d got %0d", $time, e.count, rsp_count);
               end
               if (rsp_use_translated !== e.use_x) begin
                  errors++;
                  $display("%0t: use_translated exp %0d got %0d", $time, e.use_x,
                           rsp_use_translated);
               end
               if (rsp_last !== e.last) begin
                  errors++;
                  $display("%0t: last exp %0d got %0d", $time, e.last, rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            b.op = arrt_pkg::op_type'(req_operation); b.vm = req_vm_id;
            b.start = req_range_start;
            b.len = req_range_len; b.tgt = req_target_base; b.lim = req_out_limit;
            b.fin = req_last_in_request;
            predict_beat(b);
            beat_taken = 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // driver: request side fed from pending_q, result side random stalls
   // ---------------------------------------------------------------------
   int req_gap = 0;
   int rsp_gap = 0;

   always @(negedge clock) begin
      req_beat_type b;
      if (!reset) begin
         if (!req_valid || beat_taken) begin
            if (req_gap > 0 && !calm) begin
               req_gap--;
               req_valid <= 0;
            end else if (pending_q.size() > 0) begin
               b = pending_q.pop_front();
               req_operation <= b.op; req_vm_id <= b.vm; req_range_start <= b.start;
               req_range_len <= b.len; req_target_base <= b.tgt; req_out_limit <= b.lim;
               req_last_in_request <= b.fin;
               req_valid <= 1;
               if ($urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 16);
            end else req_valid <= 0;
         end
         // result side stalls in bursts
         if (rsp_gap > 0 && !calm) begin
            rsp_gap--;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
            if ($urandom_range(0, 7) == 0) rsp_gap = $urandom_range(1, 16);
         end
      end
   end

   // watchdog on cycles with no handshake of any kind
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet <= 0;
      else if (quiet >= DOG_LIMIT) begin
         $display("address_range_region_translator verification failed");
         $finish;
      end else quiet <= quiet + 1;
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   logic [63:0] tb_first[$];
   logic [63:0] tb_last[$];

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1; csr_pwrite <= 1; csr_paddr <= addr; csr_pwdata <= data;
      csr_penable <= 0;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   function automatic void put_beat(arrt_pkg::op_type op, logic [15:0] vm, logic [63:0] s,
                                    logic [63:0] len, logic [63:0] tgt, logic [15:0] lim,
                                    logic fin);
      req_beat_type b;
      b.op = op; b.vm = vm; b.start = s; b.len = len; b.tgt = tgt; b.lim = lim; b.fin = fin;
      pending_q.push_back(b);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // blocking: everything sent, every result back, then a settling pause
   task automatic drain();
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // fresh table of n mostly adjacent regions, then commit
   function automatic void build_table(int n, logic [15:0] vm);
      logic [63:0] at, sz;
      tb_first.delete();
      tb_last.delete();
      put_beat(arrt_pkg::OP_CLEAR, vm, 0, 0, 0, 0, 0);
      at = rand64() >> 2;
      if (at == 0) at = 1;
      for (int i = 0; i < n; i++) begin
         sz = ($urandom_range(0, 9) == 0) ? (rand64() >> 8) + 1
                                          : $urandom_range(1, 1 << $urandom_range(0, 16));
         if ($urandom_range(0, 4) == 0) at += $urandom_range(1, 4096);  // hole
         tb_first.push_back(at);
         tb_last.push_back(at + sz - 1);
         // target sometimes near the top so a rebase can wrap
         put_beat(arrt_pkg::OP_ADD, vm, at, sz,
                  ($urandom_range(0, 7) == 0) ? ~64'd0 - $urandom_range(0, 64) : rand64(),
                  0, 0);
         at += sz;
      end
      put_beat(arrt_pkg::OP_COMMIT, vm, 0, 0, 0, 0, 0);
   endfunction

   // a run of ranges aimed at the table, with some noise and broken requests
   function automatic void random_request(logic [15:0] vm);
      int          nr, i, j;
      logic [63:0] s, e;
      logic [15:0] lim;
      nr  = $urandom_range(1, 4);
      lim = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
          : ($urandom_range(0, 9) == 0) ? 16'hFFFF : $urandom_range(1, 40);
      for (int k = 0; k < nr; k++) begin
         i = $urandom_range(0, tb_first.size() - 1);
         s = tb_first[i] + (rand64() % (tb_last[i] - tb_first[i] + 1));
         j = ($urandom_range(0, 2) == 0) ? $urandom_range(i, tb_first.size() - 1) : i;
         e = tb_first[j] + (rand64() % (tb_last[j] - tb_first[j] + 1));
         if (e < s) e = s;
         case ($urandom_range(0, 19))
            0:       put_beat(arrt_pkg::OP_XLATE, vm, rand64(), rand64(), rand64(), lim,
                              k == nr - 1);
            1:       put_beat(arrt_pkg::OP_XLATE, vm, s, 0, rand64(), lim, k == nr - 1);
            2:       put_beat(arrt_pkg::OP_XLATE, vm ^ 16'h8001, s, e - s + 1, 0, lim,
                              k == nr - 1);
            default: put_beat(arrt_pkg::OP_XLATE, vm, s, e - s + 1, rand64(), lim,
                              k == nr - 1);
         endcase
      end
   endfunction

   initial begin
      logic [15:0] vm;
      bit          xl;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part, table empty and uncommitted
      vm = 16'h00A5;
      csr_write(3'd0, vm);  vm_reg = vm;
      csr_write(3'd4, 1);   xlate_reg = 1;
      put_beat(arrt_pkg::OP_XLATE, vm, 64'h1000, 64'h10, 0, 4, 1);        // not valid
      put_beat(arrt_pkg::OP_ADD, vm, 0, 64'h100, 64'h5000, 0, 0);          // zero start
      put_beat(arrt_pkg::OP_ADD, vm, 64'h1000, 0, 64'h5000, 0, 0);         // zero length
      put_beat(arrt_pkg::OP_ADD, vm, ~64'd0, 64'h2, 64'h5000, 0, 0);       // overflow
      put_beat(arrt_pkg::OP_ADD, ~vm, 64'h1000, 64'h10, 0, 0, 0);          // wrong vm
      put_beat(arrt_pkg::OP_COMMIT, ~vm, 0, 0, 0, 0, 0);
      for (int i = 0; i <= NREG; i++)                                     // overfills
         put_beat(arrt_pkg::OP_ADD, vm, 64'h1000 * (i + 1), 64'h1000, ~64'd0, 0, 0);
      drain();
      build_table(3, vm);
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[0], 64'h10, 0, 0, 1);     // limit zero
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[0], tb_last[2] - tb_first[0] + 1, 0,
               16'hFFFF, 1);
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[0], tb_last[2] - tb_first[0] + 1, 0, 1, 1);
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[0] - 1, 64'h2, 0, 4, 1);  // miss / gap
      put_beat(arrt_pkg::OP_XLATE, vm, tb_last[2] + 1, 64'h10, 0, 4, 1);  // miss
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[1], 1, 0, 4, 0);
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[1], 1, 0, 4, 0);          // cached
      put_beat(arrt_pkg::OP_XLATE, ~vm, tb_first[1], 1, 0, 4, 0);         // wrong vm
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[1], 1, 0, 4, 1);          // ignored
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[0], 0, 0, 4, 1);          // zero length
      put_beat(arrt_pkg::OP_XLATE, vm, tb_first[0], ~64'd0, 0, 4, 1);     // range wraps
      drain();

      // random phases under changing settings, extremes included
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0:       begin vm = 16'h0000; xl = 0; end
            1:       begin vm = 16'hFFFF; xl = 1; end
            2:       begin vm = 16'hFFFF; xl = 0; end
            default: begin vm = $urandom; xl = $urandom_range(0, 1); end
         endcase
         csr_write(3'd0, vm); vm_reg = vm;
         csr_write(3'd4, xl); xlate_reg = xl;
         if (ph == 6) calm = 1;
         build_table($urandom_range(1, NREG), vm);
         for (int r = 0; r < 16; r++) begin
            if ($urandom_range(0, 14) == 0)
               put_beat(arrt_pkg::op_type'($urandom_range(0, 2)),
                        $urandom_range(0, 1) ? vm : $urandom,
                        rand64(), rand64(), rand64(), $urandom, $urandom_range(0, 1));
            else random_request(vm);
         end
         drain();
      end

      if (errors == 0) $display("address_range_region_translator verification clean");
      else $display("address_range_region_translator verification failed");
      $finish;
   end

endmodule
